// ----- src/tcw_pkg.sv -----
package tcw_pkg;

   localparam int DEF_COLUMNS  = 80;
   localparam int DEF_ROWS     = 25;
   localparam int DEF_TAB_STOP = 8;

   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_MOVE  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [7:0] CODE_TAB     = 8'h09;
   localparam logic [7:0] CODE_NEWLINE = 8'h0A;
   localparam logic [7:0] PRINT_LOW    = 8'h20;
   localparam logic [7:0] PRINT_HIGH   = 8'h7E;
   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] RESET_ATTR   = 8'h07;

endpackage

// ----- src/text_console_character_writer.sv -----
// an item runs the execute state, then waits in the done state for a free output register;
// newline or tab also runs the remainder states (two passes of the shared multiplier for the
// remainder), move the address state, read the address and read states; scroll and clear add
// a pass over the screen, one cell per cycle; the block is not ready while an item is at work
// reset: synchronous, active high; a clearing pass then blanks ROWS*COLUMNS cells (2000 by
// default) one per cycle before the first item is accepted
module text_console_character_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = DEF_COLUMNS,
   parameter int ROWS     = DEF_ROWS,
   parameter int TAB_STOP = DEF_TAB_STOP
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code, column, row
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // cursor_offset, mirror_char, read_char, read_attr
   output logic [0:0]  rsp_tuser    // mirror_valid
);

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int AW        = $clog2(CELLS);
   localparam int MW        = AW + 1;
   localparam int PW        = AW + MW;
   localparam int RECIP_COL = (2 ** AW) / COLUMNS;
   localparam int RECIP_TAB = (2 ** AW) / TAB_STOP;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EXEC   = 4'd1;
   localparam logic [3:0] S_ADDR   = 4'd2;
   localparam logic [3:0] S_READ   = 4'd3;
   localparam logic [3:0] S_MODQ   = 4'd4;
   localparam logic [3:0] S_MODR   = 4'd5;
   localparam logic [3:0] S_SCROLL = 4'd6;
   localparam logic [3:0] S_FILL   = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [15:0]   mem [CELLS];

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [MW-1:0] cnt_ff, cnt_in;
   logic          init_ff, init_in;
   logic [7:0]    attr_ff, attr_in;
   logic [1:0]    act_ff, act_in;
   logic [7:0]    ch_ff, ch_in;
   logic [6:0]    col_ff, col_in;
   logic [4:0]    row_ff, row_in;
   logic          is_tab_ff, is_tab_in;
   logic [PW-1:0] mul_ff, mul_in;
   logic          res_mv_ff, res_mv_in;
   logic [7:0]    res_mc_ff, res_mc_in;
   logic [7:0]    res_rc_ff, res_rc_in;
   logic [7:0]    res_ra_ff, res_ra_in;
   logic          cp_vld_ff, cp_vld_in;
   logic [AW-1:0] cp_addr_ff;
   logic [15:0]   rd_data_ff;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [39:0]   rsp_tdata_ff, rsp_tdata_in;
   logic          rsp_tuser_ff, rsp_tuser_in;

   logic [AW-1:0] mul_a_c;
   logic [MW-1:0] mul_b_c;
   logic [PW-1:0] prod_c;
   logic          wr_en_c;
   logic [AW-1:0] wr_addr_c;
   logic [15:0]   wr_data_c;
   logic [AW-1:0] rd_addr_c;
   logic [AW-1:0] row_sat_c, col_sat_c, off_c;
   logic [MW-1:0] div_c, rem0_c, rem_c, newp_c;
   logic [31:0]   pos_ext_c;
   logic          accept_c, out_free_c;

   assign req_tready = (state_ff == S_IDLE);
   assign accept_c   = req_tvalid && req_tready;
   assign out_free_c = !rsp_tvalid_ff || rsp_tready;
   assign pos_ext_c  = 32'(pos_ff);

   assign row_sat_c = ({27'b0, row_ff} > 32'(ROWS - 1)) ? AW'(ROWS - 1) : AW'(row_ff);
   assign col_sat_c = ({25'b0, col_ff} > 32'(COLUMNS - 1)) ? AW'(COLUMNS - 1) : AW'(col_ff);
   assign off_c     = mul_ff[AW-1:0] + col_sat_c;

   assign div_c  = is_tab_ff ? MW'(TAB_STOP) : MW'(COLUMNS);
   assign rem0_c = MW'(pos_ff) - mul_ff[MW-1:0];
   assign rem_c  = (rem0_c >= div_c) ? rem0_c - div_c : rem0_c;

   assign prod_c = PW'(mul_a_c) * PW'(mul_b_c);

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      init_in       = init_ff;
      attr_in       = csr_wr_en ? csr_wr_data : attr_ff;
      act_in        = act_ff;
      ch_in         = ch_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      is_tab_in     = is_tab_ff;
      mul_in        = mul_ff;
      res_mv_in     = res_mv_ff;
      res_mc_in     = res_mc_ff;
      res_rc_in     = res_rc_ff;
      res_ra_in     = res_ra_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      cp_vld_in     = 1'b0;
      mul_a_c       = pos_ff;
      mul_b_c       = MW'(RECIP_COL);
      wr_en_c       = 1'b0;
      wr_addr_c     = pos_ff;
      wr_data_c     = {attr_ff, ch_ff};
      rd_addr_c     = '0;
      newp_c        = MW'(pos_ff) + MW'(1);

      case (state_ff)
         S_IDLE: begin
            if (accept_c) begin
               act_in   = req_tuser;
               ch_in    = req_tdata[7:0];
               col_in   = req_tdata[14:8];
               row_in   = req_tdata[19:15];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_mv_in = 1'b0;
            res_mc_in = '0;
            res_rc_in = '0;
            res_ra_in = '0;
            case (act_ff)
               ACT_PUT: begin
                  if (ch_ff inside {CODE_NEWLINE, CODE_TAB, [PRINT_LOW:PRINT_HIGH]}) begin
                     res_mv_in = 1'b1;
                     res_mc_in = ch_ff;
                  end
                  if (ch_ff == CODE_NEWLINE || ch_ff == CODE_TAB) begin
                     is_tab_in = (ch_ff == CODE_TAB);
                     mul_b_c   = (ch_ff == CODE_TAB) ? MW'(RECIP_TAB) : MW'(RECIP_COL);
                     mul_in    = prod_c;
                     state_in  = S_MODQ;
                  end else begin
                     wr_en_c = 1'b1;
                     if (newp_c >= MW'(CELLS)) begin
                        pos_in   = AW'(CELLS - COLUMNS);
                        cnt_in   = '0;
                        state_in = S_SCROLL;
                     end else begin
                        pos_in   = newp_c[AW-1:0];
                        state_in = S_DONE;
                     end
                  end
               end
               ACT_MOVE, ACT_READ: begin
                  mul_a_c  = row_sat_c;
                  mul_b_c  = MW'(COLUMNS);
                  mul_in   = prod_c;
                  state_in = S_ADDR;
               end
               default: begin
                  pos_in   = '0;
                  cnt_in   = '0;
                  state_in = S_FILL;
               end
            endcase
         end
         S_ADDR: begin
            rd_addr_c = off_c;
            if (act_ff == ACT_MOVE) begin
               pos_in   = off_c;
               state_in = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            res_rc_in = rd_data_ff[7:0];
            res_ra_in = rd_data_ff[15:8];
            state_in  = S_DONE;
         end
         S_MODQ: begin
            mul_a_c  = mul_ff[2*AW-1:AW];
            mul_b_c  = div_c;
            mul_in   = prod_c;
            state_in = S_MODR;
         end
         S_MODR: begin
            newp_c = MW'(pos_ff) + div_c - rem_c;
            if (newp_c >= MW'(CELLS)) begin
               pos_in   = AW'(CELLS - COLUMNS);
               cnt_in   = '0;
               state_in = S_SCROLL;
            end else begin
               pos_in   = newp_c[AW-1:0];
               state_in = S_DONE;
            end
         end
         S_SCROLL: begin
            // read one row ahead, write the registered cell in the following cycle
            wr_en_c   = cp_vld_ff;
            wr_addr_c = cp_addr_ff;
            wr_data_c = rd_data_ff;
            if (cnt_ff < MW'(CELLS - COLUMNS)) begin
               rd_addr_c = AW'(cnt_ff + MW'(COLUMNS));
               cp_vld_in = 1'b1;
               cnt_in    = cnt_ff + MW'(1);
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            wr_en_c   = 1'b1;
            wr_addr_c = cnt_ff[AW-1:0];
            wr_data_c = {(init_ff ? RESET_ATTR : attr_ff), BLANK_CHAR};
            cnt_in    = cnt_ff + MW'(1);
            if (cnt_ff == MW'(CELLS - 1)) begin
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_DONE;
            end
         end
         S_DONE: begin
            if (out_free_c) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {5'b0, res_ra_ff, res_rc_ff, res_mc_ff, pos_ext_c[10:0]};
               rsp_tuser_in  = res_mv_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en_c) begin
         mem[wr_addr_c] <= wr_data_c;
      end
      rd_data_ff <= mem[rd_addr_c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         pos_ff        <= '0;
         cnt_ff        <= '0;
         init_ff       <= 1'b1;
         attr_ff       <= RESET_ATTR;
         cp_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         cnt_ff        <= cnt_in;
         init_ff       <= init_in;
         attr_ff       <= attr_in;
         cp_vld_ff     <= cp_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      ch_ff        <= ch_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      is_tab_ff    <= is_tab_in;
      mul_ff       <= mul_in;
      res_mv_ff    <= res_mv_in;
      res_mc_ff    <= res_mc_in;
      res_rc_ff    <= res_rc_in;
      res_ra_ff    <= res_ra_in;
      cp_addr_ff   <= cnt_ff[AW-1:0];
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      MW'(pos_ff) < MW'(CELLS))
      else $error("cursor beyond screen");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept_c |=> state_ff == S_EXEC)
      else $error("accepted item not started");

   a_copy_in_scroll: assert property (@(posedge clock) disable iff (reset)
      cp_vld_ff |-> state_ff == S_SCROLL)
      else $error("row copy outside scroll");

   a_init_fill: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> state_ff == S_FILL && !rsp_tvalid_ff)
      else $error("item work during clearing pass");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && out_free_c |=> rsp_tvalid_ff && state_ff == S_IDLE)
      else $error("finished item not presented");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import tcw_pkg::*;

   localparam int COLS  = DEF_COLUMNS;
   localparam int LINES = DEF_ROWS;
   localparam int TABW  = DEF_TAB_STOP;
   localparam int CELLS = COLS * LINES;

   typedef struct packed {
      logic [10:0] cursor_offset;
      logic        mirror_valid;
      logic [7:0]  mirror_char;
      logic [7:0]  read_char;
      logic [7:0]  read_attr;
   } console_result_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         char_code;
      logic [6:0]         column;
      logic [4:0]         row;
      logic               known;
      console_result_type result;
   } console_step_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // char_code, column, row
   logic [1:0]  req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // cursor_offset, mirror_char, read_char, read_attr
   logic [0:0]  rsp_tuser;   // mirror_valid

   logic [15:0]        screen_image [0:CELLS-1];
   int                 cursor_at;
   logic [7:0]         text_attr;
   console_result_type awaited_results [$];
   int                 items_sent;
   int                 results_seen;
   int                 errors;
   bit                 steady;
   bit                 held;
   int                 hold_left;

   localparam int DIRECTED_COUNT = 27;

   console_step_type directed_steps [0:DIRECTED_COUNT-1] = '{
      '{ACT_READ,  8'h00,        7'd0,   5'd0,  1'b1, '{11'd0,    1'b0, 8'h00, 8'h20, 8'h07}},
      '{ACT_READ,  8'h00,        7'd127, 5'd31, 1'b1, '{11'd0,    1'b0, 8'h00, 8'h20, 8'h07}},
      '{ACT_MOVE,  8'h00,        7'd127, 5'd31, 1'b1, '{11'd1999, 1'b0, 8'h00, 8'h00, 8'h00}},
      '{ACT_PUT,   8'h41,        7'd0,   5'd0,  1'b1, '{11'd1920, 1'b1, 8'h41, 8'h00, 8'h00}},
      '{ACT_READ,  8'h00,        7'd79,  5'd23, 1'b1, '{11'd1920, 1'b0, 8'h00, 8'h41, 8'h07}},
      '{ACT_PUT,   8'h00,        7'd0,   5'd0,  1'b1, '{11'd1921, 1'b0, 8'h00, 8'h00, 8'h00}},
      '{ACT_PUT,   8'hFF,        7'd127, 5'd31, 1'b1, '{11'd1922, 1'b0, 8'h00, 8'h00, 8'h00}},
      '{ACT_PUT,   8'h7E,        7'd0,   5'd0,  1'b1, '{11'd1923, 1'b1, 8'h7E, 8'h00, 8'h00}},
      '{ACT_PUT,   8'h7F,        7'd0,   5'd0,  1'b1, '{11'd1924, 1'b0, 8'h00, 8'h00, 8'h00}},
      '{ACT_PUT,   8'h1F,        7'd0,   5'd0,  1'b1, '{11'd1925, 1'b0, 8'h00, 8'h00, 8'h00}},
      '{ACT_PUT,   8'h20,        7'd0,   5'd0,  1'b1, '{11'd1926, 1'b1, 8'h20, 8'h00, 8'h00}},
      '{ACT_PUT,   CODE_TAB,     7'd0,   5'd0,  1'b0, '0},
      '{ACT_PUT,   CODE_NEWLINE, 7'd0,   5'd0,  1'b0, '0},
      '{ACT_MOVE,  8'h00,        7'd78,  5'd24, 1'b0, '0},
      '{ACT_PUT,   CODE_TAB,     7'd0,   5'd0,  1'b0, '0},
      '{ACT_MOVE,  8'hFF,        7'd0,   5'd0,  1'b1, '{11'd0,    1'b0, 8'h00, 8'h00, 8'h00}},
      '{ACT_PUT,   CODE_NEWLINE, 7'd0,   5'd0,  1'b0, '0},
      '{ACT_PUT,   CODE_TAB,     7'd0,   5'd0,  1'b0, '0},
      '{ACT_PUT,   8'h78,        7'd0,   5'd0,  1'b0, '0},
      '{ACT_READ,  8'h00,        7'd8,   5'd1,  1'b0, '0},
      '{ACT_READ,  8'h00,        7'd0,   5'd24, 1'b0, '0},
      '{ACT_CLEAR, 8'hFF,        7'd127, 5'd31, 1'b1, '{11'd0,    1'b0, 8'h00, 8'h00, 8'h00}},
      '{ACT_READ,  8'h00,        7'd5,   5'd5,  1'b1, '{11'd0,    1'b0, 8'h00, 8'h20, 8'h07}},
      '{ACT_MOVE,  8'h00,        7'd80,  5'd0,  1'b1, '{11'd79,   1'b0, 8'h00, 8'h00, 8'h00}},
      '{ACT_PUT,   CODE_TAB,     7'd0,   5'd0,  1'b0, '0},
      '{ACT_MOVE,  8'h00,        7'd0,   5'd25, 1'b1, '{11'd1920, 1'b0, 8'h00, 8'h00, 8'h00}},
      '{ACT_PUT,   CODE_NEWLINE, 7'd0,   5'd0,  1'b0, '0}
   };

   text_console_character_writer dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   assign steady = (items_sent >= 700) && (items_sent < 950);

   function automatic int cell_of(logic [6:0] column, logic [4:0] row);
      int c;
      int r;
      c = column;
      r = row;
      if (c > COLS - 1) c = COLS - 1;
      if (r > LINES - 1) r = LINES - 1;
      return r * COLS + c;
   endfunction

   function automatic void blank_from(int first);
      for (int i = first; i < CELLS; i++) screen_image[i] = {text_attr, BLANK_CHAR};
   endfunction

   function automatic console_result_type apply_console_action(logic [1:0] action,
                                                               logic [7:0] char_code,
                                                               logic [6:0] column,
                                                               logic [4:0] row);
      console_result_type res;
      int pos;
      int idx;
      res = '0;
      pos = cursor_at;
      case (action)
         ACT_PUT: begin
            if (char_code == CODE_NEWLINE || char_code == CODE_TAB ||
                (char_code >= PRINT_LOW && char_code <= PRINT_HIGH)) begin
               res.mirror_valid = 1'b1;
               res.mirror_char  = char_code;
            end
            if (char_code == CODE_NEWLINE) begin
               pos += COLS - pos % COLS;
            end else if (char_code == CODE_TAB) begin
               pos += TABW - pos % TABW;
            end else begin
               screen_image[pos] = {text_attr, char_code};
               pos++;
            end
            // scroll up one row
            if (pos >= CELLS) begin
               for (int i = 0; i < CELLS - COLS; i++) screen_image[i] = screen_image[i + COLS];
               blank_from(CELLS - COLS);
               pos = CELLS - COLS;
            end
         end
         ACT_MOVE: begin
            pos = cell_of(column, row);
         end
         ACT_READ: begin
            idx = cell_of(column, row);
            res.read_char = screen_image[idx][7:0];
            res.read_attr = screen_image[idx][15:8];
         end
         default: begin
            blank_from(0);
            pos = 0;
         end
      endcase
      cursor_at = pos;
      res.cursor_offset = pos[10:0];
      return res;
   endfunction

   task automatic offer_item(input logic [1:0] action, input logic [7:0] char_code,
                             input logic [6:0] column, input logic [4:0] row,
                             input logic known, input console_result_type typed);
      console_result_type predicted;
      while (!steady && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {4'b0, row, column, char_code};
      do @(posedge clock); while (!req_tready);
      predicted = apply_console_action(action, char_code, column, row);
      awaited_results.push_back(known ? typed : predicted);
      items_sent++;
   endtask

   task automatic random_item();
      logic [1:0] action;
      logic [7:0] char_code;
      logic [6:0] column;
      logic [4:0] row;
      int pick;
      int crow;
      pick      = $urandom_range(99);
      char_code = 8'($urandom);
      column    = 7'($urandom);
      row       = 5'($urandom);
      if (pick < 70) begin
         action = ACT_PUT;
         pick = $urandom_range(99);
         if (pick < 6) char_code = CODE_NEWLINE;
         else if (pick < 12) char_code = CODE_TAB;
         else if (pick < 75) char_code = 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
      end else if (pick < 82) begin
         action = ACT_MOVE;
         if ($urandom_range(99) < 80) begin
            column = 7'($urandom_range(0, COLS - 1));
            row    = 5'($urandom_range(0, LINES - 1));
         end
      end else if (pick < 97) begin
         action = ACT_READ;
         // half the time look at the rows just written
         if ($urandom_range(99) < 50) begin
            crow = cursor_at / COLS - $urandom_range(0, 1);
            if (crow < 0) crow = 0;
            row    = 5'(crow);
            column = 7'($urandom_range(0, COLS - 1));
         end
      end else begin
         action = ACT_CLEAR;
      end
      offer_item(action, char_code, column, row, 1'b0, '0);
   endtask

   task automatic set_attribute(input logic [7:0] value);
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      text_attr = value;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // response side
   initial begin
      console_result_type want;
      console_result_type got;
      rsp_tready = 1'b0;
      held       = 1'b0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.cursor_offset = rsp_tdata[10:0];
            got.mirror_char   = rsp_tdata[18:11];
            got.read_char     = rsp_tdata[26:19];
            got.read_attr     = rsp_tdata[34:27];
            got.mirror_valid  = rsp_tuser[0];
            results_seen++;
            if (awaited_results.size() == 0) begin
               $error("unexpected item on rsp side");
               errors++;
            end else begin
               want = awaited_results.pop_front();
               compare_field("cursor_offset", want.cursor_offset, got.cursor_offset);
               compare_field("mirror_valid", want.mirror_valid, got.mirror_valid);
               compare_field("mirror_char", want.mirror_char, got.mirror_char);
               compare_field("read_char", want.read_char, got.read_char);
               compare_field("read_attr", want.read_attr, got.read_attr);
            end
         end
         // long hold-off so the request side backs up
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held && results_seen == 300) begin
            held       = 1'b1;
            hold_left  = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 31);
         end
      end
   end

   // request side
   initial begin
      logic [7:0] phase_attr [0:4];
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 8'h00;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = ACT_PUT;
      items_sent   = 0;
      results_seen = 0;
      errors       = 0;
      cursor_at    = 0;
      text_attr    = RESET_ATTR;
      blank_from(0);
      phase_attr = '{8'h00, 8'hFF, 8'($urandom), 8'h5A, 8'($urandom)};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         offer_item(directed_steps[i].action, directed_steps[i].char_code,
                    directed_steps[i].column, directed_steps[i].row,
                    directed_steps[i].known, directed_steps[i].result);
      end
      for (int p = 0; p < 5; p++) begin
         set_attribute(phase_attr[p]);
         repeat (350) random_item();
      end
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #150_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/tcw_pkg.sv
src/text_console_character_writer.sv
sim/tb_top.sv
